// ===== rtl/binfo_pkg.sv =====
// binfo_pkg: shared types and constants of the bencode info range finder.
// Used by binfo_scan, bencode_info_range_finder and binfo_checker.
`default_nettype none

package binfo_pkg;

  // Result field widths, fixed by the output format
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned STATUS_W = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd2;

  // Scanner modes
  localparam int unsigned MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_OPEN = 3'd0; // expect the opening 'd'
  localparam logic [MODE_W-1:0] MODE_ITEM = 3'd1; // key or value type byte
  localparam logic [MODE_W-1:0] MODE_LEN  = 3'd2; // decimal string length
  localparam logic [MODE_W-1:0] MODE_BODY = 3'd3; // string body
  localparam logic [MODE_W-1:0] MODE_INT  = 3'd4; // integer body up to 'e'
  localparam logic [MODE_W-1:0] MODE_TAIL = 3'd5; // top dictionary closed

  // Bencode syntax bytes
  localparam logic [7:0] CH_DICT  = 8'h64; // 'd'
  localparam logic [7:0] CH_LIST  = 8'h6c; // 'l'
  localparam logic [7:0] CH_INT   = 8'h69; // 'i'
  localparam logic [7:0] CH_END   = 8'h65; // 'e'
  localparam logic [7:0] CH_COLON = 8'h3a; // ':'
  localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CH_NINE  = 8'h39; // '9'

  // The key being searched for
  localparam int unsigned KEY_LEN = 4;

  function automatic logic [7:0] key_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h69; // 'i'
      2'd1:    c = 8'h6e; // 'n'
      2'd2:    c = 8'h66; // 'f'
      default: c = 8'h6f; // 'o'
    endcase
    return c;
  endfunction

  // One result as produced by the scanner
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    info_begin;
    logic [OUT_W-1:0]    info_end;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/binfo_scan.sv =====
// binfo_scan: bencode byte scanner; holds the parse state and gives at most
// one result per byte. Depends on binfo_pkg.
`default_nettype none

module binfo_scan #(
  parameter int unsigned OFFSET_BITS = 24,
  parameter int unsigned DEPTH_BITS  = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,   // process one byte this cycle
  input  wire logic [7:0]        byte_i,
  input  wire logic              first_i,
  input  wire logic              last_i,
  output binfo_pkg::result_t     result_o
);

  localparam int unsigned LEN_W = OFFSET_BITS + 4;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX   = {OFFSET_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0]  DEPTH_ONE = DEPTH_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] OFF_ONE   = OFFSET_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] KEY_LEN_O = OFFSET_BITS'(binfo_pkg::KEY_LEN);
  localparam logic [2:0]             KEY_LEN_C = 3'(binfo_pkg::KEY_LEN);

  logic [OFFSET_BITS-1:0]      offset_q, offset_d;
  logic [DEPTH_BITS-1:0]       depth_q, depth_d;
  logic [binfo_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [OFFSET_BITS-1:0]      len_q, len_d;
  logic [OFFSET_BITS-1:0]      left_q, left_d;
  logic [2:0]                  match_q, match_d;
  logic                        mismatch_q, mismatch_d;
  logic                        key_q, key_d;
  logic                        capture_q, capture_d;
  logic [OFFSET_BITS-1:0]      start_q, start_d;
  logic                        done_q, done_d;

  logic                        is_digit;
  logic [3:0]                  digit;
  logic [LEN_W-1:0]            len_wide;
  logic [OFFSET_BITS-1:0]      off;
  logic                        str_end;
  logic                        val_end;
  logic                        res_v;
  logic                        res_found;
  logic [binfo_pkg::STATUS_W-1:0] res_st;

  assign is_digit = (byte_i >= binfo_pkg::CH_ZERO) && (byte_i <= binfo_pkg::CH_NINE);
  assign digit    = 4'(byte_i - binfo_pkg::CH_ZERO);
  // len * 10 + digit, wide enough to see the overflow
  assign len_wide = (LEN_W'(len_q) << 3) + (LEN_W'(len_q) << 1) + LEN_W'(digit);

  always_comb begin
    // a first byte restarts from the reset state
    if (first_i) begin
      offset_d   = '0;
      depth_d    = '0;
      mode_d     = binfo_pkg::MODE_OPEN;
      len_d      = '0;
      left_d     = '0;
      match_d    = '0;
      mismatch_d = 1'b0;
      key_d      = 1'b0;
      capture_d  = 1'b0;
      start_d    = '0;
      done_d     = 1'b0;
    end else begin
      offset_d   = offset_q;
      depth_d    = depth_q;
      mode_d     = mode_q;
      len_d      = len_q;
      left_d     = left_q;
      match_d    = match_q;
      mismatch_d = mismatch_q;
      key_d      = key_q;
      capture_d  = capture_q;
      start_d    = start_q;
      done_d     = done_q;
    end
    off       = offset_d;
    str_end   = 1'b0;
    val_end   = 1'b0;
    res_v     = 1'b0;
    res_found = 1'b0;
    res_st    = binfo_pkg::STATUS_MALFORMED;

    if (!done_d) begin
      if (mode_d != binfo_pkg::MODE_TAIL && off == OFF_MAX) begin
        res_v = 1'b1; // offset overflow
      end else begin
        case (mode_d)
          binfo_pkg::MODE_OPEN: begin
            if (byte_i == binfo_pkg::CH_DICT) begin
              depth_d    = DEPTH_ONE;
              key_d      = 1'b1;
              match_d    = '0;
              mismatch_d = 1'b0;
              mode_d     = binfo_pkg::MODE_ITEM;
            end else begin
              res_v = 1'b1;
            end
          end
          binfo_pkg::MODE_ITEM: begin
            if (key_d) begin
              if (byte_i == binfo_pkg::CH_END) begin
                depth_d = '0;
                mode_d  = binfo_pkg::MODE_TAIL;
              end else if (is_digit) begin
                len_d  = OFFSET_BITS'(digit);
                mode_d = binfo_pkg::MODE_LEN;
              end else begin
                res_v = 1'b1;
              end
            end else if (byte_i == binfo_pkg::CH_DICT || byte_i == binfo_pkg::CH_LIST) begin
              if (depth_d == DEPTH_MAX) begin
                res_v = 1'b1; // depth overflow
              end else begin
                depth_d = depth_d + DEPTH_ONE;
              end
            end else if (byte_i == binfo_pkg::CH_INT) begin
              mode_d = binfo_pkg::MODE_INT;
            end else if (is_digit) begin
              len_d  = OFFSET_BITS'(digit);
              mode_d = binfo_pkg::MODE_LEN;
            end else if (byte_i == binfo_pkg::CH_END && depth_d > DEPTH_ONE) begin
              depth_d = depth_d - DEPTH_ONE;
              val_end = (depth_d == DEPTH_ONE);
            end else begin
              res_v = 1'b1; // bad type byte
            end
          end
          binfo_pkg::MODE_LEN: begin
            if (is_digit) begin
              len_d = len_wide[OFFSET_BITS-1:0];
              if (len_wide[LEN_W-1:OFFSET_BITS] != '0) begin
                res_v = 1'b1; // length overflow
              end
            end else if (byte_i == binfo_pkg::CH_COLON) begin
              left_d = len_d;
              if (key_d && len_d != KEY_LEN_O) begin
                mismatch_d = 1'b1;
              end
              if (len_d == '0) begin
                str_end = 1'b1;
              end else begin
                mode_d = binfo_pkg::MODE_BODY;
              end
            end else begin
              res_v = 1'b1; // missing ':'
            end
          end
          binfo_pkg::MODE_BODY: begin
            if (key_d) begin
              if (match_d < KEY_LEN_C && byte_i == binfo_pkg::key_char(match_d[1:0])) begin
                match_d = match_d + 3'd1;
              end else begin
                mismatch_d = 1'b1;
              end
            end
            left_d  = left_d - OFF_ONE;
            str_end = (left_d == '0);
          end
          binfo_pkg::MODE_INT: begin
            val_end = (byte_i == binfo_pkg::CH_END);
          end
          default: begin
          end
        endcase
      end

      // end of a string: a key, or a value that ends
      if (str_end) begin
        if (key_d) begin
          if (!mismatch_d && match_d == KEY_LEN_C) begin
            capture_d = 1'b1;
            start_d   = off + OFF_ONE;
          end
          key_d  = 1'b0;
          mode_d = binfo_pkg::MODE_ITEM;
        end else begin
          val_end = 1'b1;
        end
      end

      // end of a value; at the top level this is either the info value or
      // the cue to read the next key
      if (val_end) begin
        mode_d = binfo_pkg::MODE_ITEM;
        if (depth_d == DEPTH_ONE) begin
          if (capture_d) begin
            res_v     = 1'b1;
            res_found = 1'b1;
            res_st    = binfo_pkg::STATUS_FOUND;
          end else begin
            key_d      = 1'b1;
            match_d    = '0;
            mismatch_d = 1'b0;
          end
        end
      end

      if (!res_v) begin
        if (mode_d != binfo_pkg::MODE_TAIL) begin
          offset_d = off + OFF_ONE;
        end
        if (last_i) begin
          res_v  = 1'b1;
          res_st = (mode_d == binfo_pkg::MODE_TAIL) ? binfo_pkg::STATUS_NOT_FOUND
                                                    : binfo_pkg::STATUS_MALFORMED;
        end
      end
      if (res_v) begin
        done_d = 1'b1;
      end
    end

    result_o.valid      = res_v;
    result_o.status     = res_st;
    result_o.info_begin = res_found ? binfo_pkg::OUT_W'(start_d) : '0;
    result_o.info_end   = res_found ? binfo_pkg::OUT_W'(off + OFF_ONE) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      depth_q    <= '0;
      mode_q     <= binfo_pkg::MODE_OPEN;
      len_q      <= '0;
      left_q     <= '0;
      match_q    <= '0;
      mismatch_q <= 1'b0;
      key_q      <= 1'b0;
      capture_q  <= 1'b0;
      start_q    <= '0;
      done_q     <= 1'b0;
    end else if (step_i) begin
      offset_q   <= offset_d;
      depth_q    <= depth_d;
      mode_q     <= mode_d;
      len_q      <= len_d;
      left_q     <= left_d;
      match_q    <= match_d;
      mismatch_q <= mismatch_d;
      key_q      <= key_d;
      capture_q  <= capture_d;
      start_q    <= start_d;
      done_q     <= done_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bencode_info_range_finder.sv =====
// bencode_info_range_finder: top level; input register, scanner and result
// register with stream handshakes. Depends on binfo_pkg and binfo_scan.
//
//  channel  | dir | tdata                     | tuser        | tlast
//  s_axis   | in  | [7:0] data_byte           | first_byte   | last_byte
//  m_axis   | out | [23:0] info_begin,        | [1:0] status | -
//           |     | [47:24] info_end          |              |
//
// One byte per cycle, sustained while the result register is not stalled: a
// byte is parsed by the scanner while it sits in the input register, and its
// result, if any, is loaded into the result register as the scanner takes it.
// The parse state update is a loop through the scanner's own registers.
// Reset is asynchronous, active low, and also leaves the scanner waiting for
// the opening 'd'. A stalled result register holds the scanner and, once the
// input register is full, drops s_axis_tready_o; both sides stall freely.
`default_nettype none

module bencode_info_range_finder #(
  parameter int unsigned OFFSET_BITS = 24, // 16..32, offset counter width
  parameter int unsigned DEPTH_BITS  = 8   // 4..16, nesting depth counter width
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] first_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  // result stream
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [47:0] m_axis_tdata_o,   // [23:0] info_begin, [47:24] info_end
  output      logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       in_last_q;

  // result register
  logic                               out_valid_q;
  logic [binfo_pkg::STATUS_W-1:0]     out_status_q;
  logic [binfo_pkg::OUT_W-1:0]        out_begin_q;
  logic [binfo_pkg::OUT_W-1:0]        out_end_q;

  logic               advance;   // scanner takes the held byte this cycle
  logic               s_take;
  binfo_pkg::result_t scan_res;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i;
      in_last_q  <= s_axis_tlast_i;
    end
  end

  binfo_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .first_i  (in_first_q),
    .last_i   (in_last_q),
    .result_o (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= scan_res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && scan_res.valid) begin
      out_status_q <= scan_res.status;
      out_begin_q  <= scan_res.info_begin;
      out_end_q    <= scan_res.info_end;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_end_q, out_begin_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

`default_nettype wire

// ===== rtl/binfo_checker.sv =====
// binfo_checker: port-level checks of bencode_info_range_finder, bound to
// the top level below. Depends on binfo_pkg.
`default_nettype none

module binfo_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result withdrawn while stalled");

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == binfo_pkg::STATUS_FOUND ||
                         m_axis_tuser_o == binfo_pkg::STATUS_NOT_FOUND ||
                         m_axis_tuser_o == binfo_pkg::STATUS_MALFORMED))
    else $error("undefined status code");

  // range is zero unless info was found
  a_zero_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != binfo_pkg::STATUS_FOUND
      |-> m_axis_tdata_o == '0)
    else $error("non-zero range without a found status");

  // a found range is never empty
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == binfo_pkg::STATUS_FOUND
      |-> m_axis_tdata_o[47:24] > m_axis_tdata_o[23:0])
    else $error("info range end not past its start");

  // a fresh result follows an earlier byte transaction
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result without a preceding byte");

endmodule

bind bencode_info_range_finder binfo_checker u_binfo_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// ===== tb/bencode_info_range_finder_test.sv =====
// bencode_info_range_finder_test: self-checking bench for the bencode info range finder.
// Carries its own byte-level model of the info locator in a scoreboard class.
// Needs binfo_pkg and bencode_info_range_finder, nothing else.

localparam int unsigned     OFFSET_W  = 24;
localparam int unsigned     DEPTH_W   = 8;
localparam longint unsigned OFF_LAST  = (64'd1 << OFFSET_W) - 1;
localparam int unsigned     DEPTH_TOP = (1 << DEPTH_W) - 1;

typedef struct {
  logic [binfo_pkg::STATUS_W-1:0] status;
  logic [binfo_pkg::OUT_W-1:0]    info_begin;
  logic [binfo_pkg::OUT_W-1:0]    info_end;
} info_span_t;

class info_range_board;
  info_span_t span_q[$];
  int unsigned errors;
  int unsigned n_seen;

  longint unsigned              offs;
  longint unsigned              len_acc;
  longint unsigned              str_left;
  longint unsigned              span_start;
  longint unsigned              span_stop;
  int unsigned                  depth;
  int unsigned                  key_hits;
  logic [binfo_pkg::MODE_W-1:0] mode;
  bit                           key_bad;
  bit                           in_key;
  bit                           capturing;
  bit                           done;
  logic [31:0]                  key_word;

  function new();
    errors   = 0;
    n_seen   = 0;
    key_word = "info";
    restart();
  endfunction

  function void restart();
    offs       = 0;
    depth      = 0;
    mode       = binfo_pkg::MODE_OPEN;
    len_acc    = 0;
    str_left   = 0;
    key_hits   = 0;
    key_bad    = 0;
    in_key     = 0;
    capturing  = 0;
    span_start = 0;
    span_stop  = 0;
    done       = 0;
  endfunction

  function bit is_digit(logic [7:0] b);
    return b >= binfo_pkg::CH_ZERO && b <= binfo_pkg::CH_NINE;
  endfunction

  // A value ended on offset off; 1 when it was the info value.
  function bit value_closed(longint unsigned off);
    mode = binfo_pkg::MODE_ITEM;
    if (depth == 1) begin
      if (capturing) begin
        span_stop = off + 1;
        return 1;
      end
      in_key   = 1;
      key_hits = 0;
      key_bad  = 0;
    end
    return 0;
  endfunction

  function bit string_closed(longint unsigned off);
    if (!in_key) return value_closed(off);
    if (!key_bad && key_hits == binfo_pkg::KEY_LEN) begin
      capturing  = 1;
      span_start = off + 1;
    end
    in_key = 0;
    mode   = binfo_pkg::MODE_ITEM;
    return 0;
  endfunction

  // Parses one accepted byte; 0 when the byte is ignored (scan already over).
  function bit note_byte(logic [7:0] b, bit first, bit last);
    longint unsigned                off;
    bit                             bad;
    bit                             found;
    logic [binfo_pkg::STATUS_W-1:0] st;
    info_span_t                     s;
    if (first) restart();
    if (done) return 0;
    off   = offs;
    bad   = 0;
    found = 0;
    if (mode != binfo_pkg::MODE_TAIL && off >= OFF_LAST) begin
      bad = 1;
    end else begin
      case (mode)
        binfo_pkg::MODE_OPEN: begin
          if (b == binfo_pkg::CH_DICT) begin
            depth    = 1;
            in_key   = 1;
            key_hits = 0;
            key_bad  = 0;
            mode     = binfo_pkg::MODE_ITEM;
          end else begin
            bad = 1;
          end
        end
        binfo_pkg::MODE_ITEM: begin
          if (in_key) begin
            if (b == binfo_pkg::CH_END) begin
              depth = 0;
              mode  = binfo_pkg::MODE_TAIL;
            end else if (is_digit(b)) begin
              len_acc = b - binfo_pkg::CH_ZERO;
              mode    = binfo_pkg::MODE_LEN;
            end else begin
              bad = 1;
            end
          end else if (b == binfo_pkg::CH_DICT || b == binfo_pkg::CH_LIST) begin
            if (depth >= DEPTH_TOP) bad = 1;
            else depth++;
          end else if (b == binfo_pkg::CH_INT) begin
            mode = binfo_pkg::MODE_INT;
          end else if (is_digit(b)) begin
            len_acc = b - binfo_pkg::CH_ZERO;
            mode    = binfo_pkg::MODE_LEN;
          end else if (b == binfo_pkg::CH_END && depth > 1) begin
            depth--;
            if (depth == 1) found = value_closed(off);
          end else begin
            bad = 1;
          end
        end
        binfo_pkg::MODE_LEN: begin
          if (is_digit(b)) begin
            len_acc = len_acc * 10 + (b - binfo_pkg::CH_ZERO);
            if (len_acc > OFF_LAST) bad = 1;
          end else if (b == binfo_pkg::CH_COLON) begin
            str_left = len_acc;
            if (in_key && len_acc != binfo_pkg::KEY_LEN) key_bad = 1;
            if (len_acc == 0) found = string_closed(off);
            else mode = binfo_pkg::MODE_BODY;
          end else begin
            bad = 1;
          end
        end
        binfo_pkg::MODE_BODY: begin
          if (in_key) begin
            if (key_hits < binfo_pkg::KEY_LEN &&
                b == key_word[8*(3-key_hits) +: 8]) key_hits++;
            else key_bad = 1;
          end
          str_left--;
          if (str_left == 0) found = string_closed(off);
        end
        binfo_pkg::MODE_INT: begin
          if (b == binfo_pkg::CH_END) found = value_closed(off);
        end
        default: ;
      endcase
    end

    if (!bad && !found) begin
      if (mode != binfo_pkg::MODE_TAIL) offs = (off + 1) & OFF_LAST;
      if (!last) return 1;
      st = (mode == binfo_pkg::MODE_TAIL) ? binfo_pkg::STATUS_NOT_FOUND
                                          : binfo_pkg::STATUS_MALFORMED;
    end else begin
      st = bad ? binfo_pkg::STATUS_MALFORMED : binfo_pkg::STATUS_FOUND;
    end
    s.status     = st;
    s.info_begin = '0;
    s.info_end   = '0;
    if (st == binfo_pkg::STATUS_FOUND) begin
      s.info_begin = span_start[binfo_pkg::OUT_W-1:0];
      s.info_end   = span_stop[binfo_pkg::OUT_W-1:0];
    end
    done = 1;
    span_q.push_back(s);
    return 1;
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic [binfo_pkg::STATUS_W-1:0] st,
                    logic [binfo_pkg::OUT_W-1:0] beg,
                    logic [binfo_pkg::OUT_W-1:0] fin);
    info_span_t w;
    n_seen++;
    if (span_q.size() == 0) begin
      report($sformatf("result %0d: status %0d, none outstanding", n_seen, st));
      return;
    end
    w = span_q.pop_front();
    if (st !== w.status)
      report($sformatf("result %0d: status %0d, want %0d", n_seen, st, w.status));
    if (beg !== w.info_begin)
      report($sformatf("result %0d: info_begin %0d, want %0d", n_seen, beg, w.info_begin));
    if (fin !== w.info_end)
      report($sformatf("result %0d: info_end %0d, want %0d", n_seen, fin, w.info_end));
  endtask

  task flush_leftovers();
    while (span_q.size() != 0) begin
      report($sformatf("status %0d never produced", span_q[0].status));
      void'(span_q.pop_front());
    end
  endtask
endclass

module bencode_info_range_finder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape: random files go on until the byte budget is spent.
  localparam int unsigned TOTAL_BYTES  = 650;
  // Leave a margin for stray results.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Under a thousand bytes with stalls on both sides; this is well clear.
  localparam int unsigned CYCLE_LIMIT  = 400_000;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  bencode_info_range_finder #(
    .OFFSET_BITS(OFFSET_W),
    .DEPTH_BITS (DEPTH_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // [7:0] data_byte
    .s_axis_tuser_i (s_tuser),   // [0] first_byte
    .s_axis_tlast_i (s_tlast),   // last_byte
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),   // [23:0] info_begin, [47:24] info_end
    .m_axis_tuser_o (m_tuser)    // [1:0] status
  );

  info_range_board board;
  logic [7:0]      file_q[$];    // bytes of the file being built
  bit              src_busy = 1'b0;
  bit              snk_busy = 1'b0;
  int unsigned     sent_bytes = 0;
  int unsigned     cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bencode_info_range_finder_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source. Entered and left at a falling edge; tvalid only drops when a
  // gap is drawn, so back-to-back transactions keep it high throughout.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
    int unsigned gap;
    gap = src_busy ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tuser  = first;
    s_tlast  = last;
    do begin
      @(posedge clk_i);
    end while (!s_tready);
    // Accepted at this edge: the model steps before the result can appear.
    void'(board.note_byte(b, first, last));
    sent_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_file(input bit with_first, input bit with_last);
    for (int k = 0; k < file_q.size(); k++)
      send_byte(file_q[k], with_first && k == 0, with_last && k == file_q.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // File builders. Everything is appended to file_q.
  // ---------------------------------------------------------------------------
  function automatic void add_text(string s);
    for (int k = 0; k < s.len(); k++) file_q.push_back(s[k]);
  endfunction

  // String with arbitrary byte content, so every data bit toggles.
  function automatic void add_string(int unsigned n);
    if ($urandom_range(0, 9) == 0) file_q.push_back(binfo_pkg::CH_ZERO);   // leading zero
    add_text($sformatf("%0d:", n));
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  // Keys lean heavily on "info" and near misses of it.
  function automatic void add_key();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      add_text("4:info");
    end else if (pick < 6) begin
      case ($urandom_range(0, 4))
        0:       add_text("3:inf");
        1:       add_text("5:infos");
        2:       add_text("4:infO");
        3:       add_text("4:nfoi");
        default: add_text("5:iinfo");
      endcase
    end else begin
      add_string($urandom_range(0, 6));
    end
  endfunction

  // Integer; the body is not checked, so junk is sometimes thrown in.
  function automatic void add_int();
    logic [7:0] junk;
    file_q.push_back(binfo_pkg::CH_INT);
    if ($urandom_range(0, 3) == 0) add_text("-");
    repeat ($urandom_range(1, 6))
      file_q.push_back(8'($urandom_range(binfo_pkg::CH_ZERO, binfo_pkg::CH_NINE)));
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        do junk = 8'($urandom); while (junk == binfo_pkg::CH_END);
        file_q.push_back(junk);
      end
    end
    file_q.push_back(binfo_pkg::CH_END);
  endfunction

  function automatic void add_value(int unsigned lvl);
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, (lvl < 4) ? 3 : 1);
    n    = $urandom_range(0, 3);
    case (kind)
      0: add_int();
      1: add_string(($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8));
      2: begin
        file_q.push_back(binfo_pkg::CH_LIST);
        repeat (n) add_value(lvl + 1);
        file_q.push_back(binfo_pkg::CH_END);
      end
      default: begin
        // nested dict: its keys may say "info" too and must not count
        file_q.push_back(binfo_pkg::CH_DICT);
        repeat (n) begin
          add_key();
          add_value(lvl + 1);
        end
        file_q.push_back(binfo_pkg::CH_END);
      end
    endcase
  endfunction

  function automatic void build_file();
    file_q.delete();
    file_q.push_back(binfo_pkg::CH_DICT);
    repeat ($urandom_range(0, 4)) begin
      add_key();
      add_value(1);
    end
    file_q.push_back(binfo_pkg::CH_END);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom));
  endfunction

  // Break a well-formed file: flip a byte, plant a syntax byte, cut it short,
  // or throw it away for plain noise.
  function automatic void damage_file();
    int unsigned at;
    at = $urandom_range(0, file_q.size() - 1);
    case ($urandom_range(0, 3))
      0: file_q[at] = 8'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0:       file_q[at] = binfo_pkg::CH_DICT;
          1:       file_q[at] = binfo_pkg::CH_LIST;
          2:       file_q[at] = binfo_pkg::CH_INT;
          3:       file_q[at] = binfo_pkg::CH_END;
          4:       file_q[at] = binfo_pkg::CH_COLON;
          default: file_q[at] = 8'($urandom_range(binfo_pkg::CH_ZERO, binfo_pkg::CH_NINE));
        endcase
      end
      2: while (file_q.size() > at + 1) void'(file_q.pop_back());
      default: begin
        file_q.delete();
        file_q.push_back($urandom_range(0, 1) ? binfo_pkg::CH_DICT : 8'($urandom));
        repeat ($urandom_range(0, 11)) file_q.push_back(8'($urandom));
      end
    endcase
  endfunction

  task automatic run_text(input string s, input bit first, input bit last);
    file_q.delete();
    add_text(s);
    send_file(first, last);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: a fresh stall is drawn for every transaction, with spells of
  // no stalling at all. Fields are sampled at the accepting edge.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 7) == 0) snk_busy = !snk_busy;
      stall = snk_busy ? $urandom_range(0, 15) : 0;
      @(negedge clk_i);
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready = 1'b1;
      do begin
        @(posedge clk_i);
      end while (!m_tvalid);
      board.check_result(m_tuser, m_tdata[23:0], m_tdata[47:24]);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bit first;
    bit last;
    board = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed files. Stalls are on so gaps land around the special cases.
    src_busy = 1'b1;
    run_text("d4:infoi5ee", 0, 1);        // first byte after reset without first_byte
    run_text("x", 1, 1);                  // opening byte not 'd'
    run_text("e", 1, 1);
    run_text("de", 1, 1);                 // empty dict: not found at the last byte
    run_text("d", 1, 1);                  // truncated on the opening byte
    run_text("dx", 1, 1);                 // key slot holds junk
    run_text("d4:infoxe", 1, 1);          // bad type byte
    run_text("d3:abce", 1, 1);            // 'e' in a value slot at the top level
    run_text("d4x", 1, 1);                // length not closed by ':'
    run_text("d16777215:", 1, 1);         // largest length, then truncated
    run_text("d16777216:", 1, 1);         // length overflow
    run_text("d4:info0:e", 1, 1);         // empty string as the info value
    run_text("d0:i1e04:infol1:ai-3eee", 1, 1);  // empty key, leading zero, list value
    run_text("d3:inf1:x5:infox1:y4:INFO1:z4:infod4:infoi1eee", 1, 1);
    run_text("d4:infoi1e", 1, 1);         // info completes on the last byte
    run_text("d1:ai12x-:ee4:infoi0ee", 1, 1);   // junk inside an integer
    run_text("d1:a1:bezz!", 1, 1);        // bytes after the close are skipped
    run_text("d4:infold1:ai1eeee", 1, 1); // nested containers inside info
    run_text("d4:info1:a4:info1:be", 1, 1);     // second info key is never reached
    run_text("d4:in", 1, 0);              // abandoned mid-key ...
    run_text("d4:info3:abce", 1, 1);      // ... and restarted by first_byte
    run_text("zz", 0, 1);                 // after a result: ignored, no result

    // Extreme data values in keys and values.
    file_q.delete();
    add_text("d2:");
    file_q.push_back(8'h00);
    file_q.push_back(8'hff);
    add_text("4:info4:info2:");
    file_q.push_back(8'hff);
    file_q.push_back(8'h00);
    file_q.push_back(binfo_pkg::CH_END);
    send_file(1, 1);

    // Deepest legal nesting inside info, then one level too many.
    src_busy = 1'b0;
    file_q.delete();
    add_text("d4:info");
    repeat (DEPTH_TOP) file_q.push_back(binfo_pkg::CH_LIST);
    send_file(1, 1);
    // Offset overflow needs 2^24 bytes in one file and is left to a long run.

    // Random files: mostly well formed with random content, the rest damaged,
    // left open, or sent without first_byte so they run on from the last file.
    while (sent_bytes < TOTAL_BYTES) begin
      src_busy = ($urandom_range(0, 3) != 0);
      build_file();
      if ($urandom_range(0, 9) < 3) damage_file();
      first = ($urandom_range(0, 19) != 0);
      last  = ($urandom_range(0, 9) != 0);
      send_file(first, last);
    end
    s_tvalid = 1'b0;

    while (board.span_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    board.flush_leftovers();
    if (board.errors == 0) begin
      $display("bencode_info_range_finder_test: PASS");
    end else begin
      $display("bencode_info_range_finder_test: FAIL");
    end
    $finish;
  end
endmodule
